>>> hdl/tcgr_pkg.sv
`timescale 1ns / 1ps

package tcgr_pkg;

    localparam int GRID_ROWS  = 25;
    localparam int GRID_COLS  = 80;
    localparam int CELL_LINES = 16;

    localparam int OFFSET_W   = 25;
    localparam int LINE_W     = $clog2(CELL_LINES);
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_LINE_PITCH     = 3'd0,
        CFG_PIXEL_BYTES    = 3'd1,
        CFG_RED_POSITION   = 3'd2,
        CFG_RED_SIZE       = 3'd3,
        CFG_GREEN_POSITION = 3'd4,
        CFG_GREEN_SIZE     = 3'd5,
        CFG_BLUE_POSITION  = 3'd6,
        CFG_BLUE_SIZE      = 3'd7
    } t_cfg_reg;

    typedef struct packed {
        logic [15:0] line_pitch;
        logic [2:0]  pixel_bytes;
        logic [4:0]  red_position;
        logic [3:0]  red_size;
        logic [4:0]  green_position;
        logic [3:0]  green_size;
        logic [4:0]  blue_position;
        logic [3:0]  blue_size;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        line_pitch:     16'd0,
        pixel_bytes:    3'd4,
        red_position:   5'd16,
        red_size:       4'd8,
        green_position: 5'd8,
        green_size:     4'd8,
        blue_position:  5'd0,
        blue_size:      4'd8
    };

    typedef enum logic [4:0] {
        G_D0 = 5'd0, G_D1 = 5'd1, G_D2 = 5'd2, G_D3 = 5'd3, G_D4 = 5'd4,
        G_D5 = 5'd5, G_D6 = 5'd6, G_D7 = 5'd7, G_D8 = 5'd8, G_D9 = 5'd9,
        G_SPACE  = 5'd10,
        G_HYPHEN = 5'd11,
        G_LC_D   = 5'd12,
        G_LC_E   = 5'd13,
        G_LC_F   = 5'd14,
        G_LC_I   = 5'd15,
        G_LC_L   = 5'd16,
        G_LC_N   = 5'd17,
        G_LC_O   = 5'd18,
        G_LC_S   = 5'd19,
        G_QUEST  = 5'd20
    } t_glyph;

    typedef struct packed {
        logic [OFFSET_W-1:0] base;
        t_glyph              glyph;
    } t_job;

    function automatic t_glyph classify(input logic [7:0] code);
        t_glyph g;
        logic [7:0] d;
        d = code - 8'h30;
        if (code >= 8'h30 && code <= 8'h39) begin
            g = t_glyph'(d[4:0]);
        end else begin
            unique case (code)
                8'h20:   g = G_SPACE;
                8'h2D:   g = G_HYPHEN;
                8'h64:   g = G_LC_D;
                8'h65:   g = G_LC_E;
                8'h66:   g = G_LC_F;
                8'h69:   g = G_LC_I;
                8'h6C:   g = G_LC_L;
                8'h6E:   g = G_LC_N;
                8'h6F:   g = G_LC_O;
                8'h73:   g = G_LC_S;
                default: g = G_QUEST;
            endcase
        end
        return g;
    endfunction

    // glyph rows packed top row first
    function automatic logic [7:0] font_row(input t_glyph g, input logic [2:0] r);
        logic [63:0] w;
        logic [63:0] s;
        unique case (g)
            G_D0:     w = 64'h3C666E7666663C00;
            G_D1:     w = 64'h1838181818187E00;
            G_D2:     w = 64'h3C66061C30607E00;
            G_D3:     w = 64'h3C66061C06663C00;
            G_D4:     w = 64'h0C1C3C6C7E0C0C00;
            G_D5:     w = 64'h7E607C0606663C00;
            G_D6:     w = 64'h1C30607C66663C00;
            G_D7:     w = 64'h7E660C1818181800;
            G_D8:     w = 64'h3C66663C66663C00;
            G_D9:     w = 64'h3C66663E060C3800;
            G_SPACE:  w = 64'h0000000000000000;
            G_HYPHEN: w = 64'h0000007E00000000;
            G_LC_D:   w = 64'h0C0C3C6C6C6C3600;
            G_LC_E:   w = 64'h00003C667E603C00;
            G_LC_F:   w = 64'h1C30307C30303000;
            G_LC_I:   w = 64'h1800381818183C00;
            G_LC_L:   w = 64'h3818181818183C00;
            G_LC_N:   w = 64'h00006C7666666600;
            G_LC_O:   w = 64'h00003C6666663C00;
            G_LC_S:   w = 64'h00003E603C067C00;
            default:  w = 64'h3C66060C18001800;
        endcase
        s = w >> {~r, 3'b000};
        return s[7:0];
    endfunction

    function automatic logic [31:0] component(input logic [3:0] size,
                                              input logic [4:0] pos);
        logic [3:0] n;
        logic [8:0] m;
        n = (size > 4'd8) ? 4'd8 : size;
        m = (9'd1 << n) - 9'd1;
        return {24'd0, m[7:0]} << pos;
    endfunction

    function automatic logic [31:0] white_value(input t_cfg c);
        logic [31:0] v;
        v = component(c.red_size, c.red_position)
          | component(c.green_size, c.green_position)
          | component(c.blue_size, c.blue_position);
        if (c.pixel_bytes == 3'd3) begin
            v = v & 32'h00FF_FFFF;
        end
        return v;
    endfunction

endpackage

>>> hdl/text_cell_glyph_renderer.sv
// The first scanline item is registered in the output stage after the cell item
// has been written to the job queue.
// Each in-grid cell gives 16 scanlines, one scanline per cycle from the back
// sequencer unless i_out_ready stalls it; cells outside the grid give nothing.
// Reset (synchronous, active low): config registers to defaults, queue and
// output stage emptied.
`timescale 1ns / 1ps

module text_cell_glyph_renderer (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [tcgr_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [tcgr_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [4:0]                          i_cell_row,
    input  logic [6:0]                          i_cell_column,
    input  logic [7:0]                          i_char_code,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [tcgr_pkg::OFFSET_W-1:0]       o_scanline_offset,
    output logic [7:0]                          o_pixel_mask,
    output logic [31:0]                         o_fore_color,
    output logic                                o_last_scanline
);

    tcgr_pkg::t_cfg r_cfg;
    tcgr_pkg::t_job push_job;
    tcgr_pkg::t_job head_job;
    logic           push;
    logic           pop;
    logic           queue_full;
    logic           head_valid;
    logic [31:0]    white;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= tcgr_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (tcgr_pkg::t_cfg_reg'(i_cfg_index))
                tcgr_pkg::CFG_LINE_PITCH:     r_cfg.line_pitch     <= i_cfg_data;
                tcgr_pkg::CFG_PIXEL_BYTES:    r_cfg.pixel_bytes    <= i_cfg_data[2:0];
                tcgr_pkg::CFG_RED_POSITION:   r_cfg.red_position   <= i_cfg_data[4:0];
                tcgr_pkg::CFG_RED_SIZE:       r_cfg.red_size       <= i_cfg_data[3:0];
                tcgr_pkg::CFG_GREEN_POSITION: r_cfg.green_position <= i_cfg_data[4:0];
                tcgr_pkg::CFG_GREEN_SIZE:     r_cfg.green_size     <= i_cfg_data[3:0];
                tcgr_pkg::CFG_BLUE_POSITION:  r_cfg.blue_position  <= i_cfg_data[4:0];
                tcgr_pkg::CFG_BLUE_SIZE:      r_cfg.blue_size      <= i_cfg_data[3:0];
                default:                      r_cfg                <= r_cfg;
            endcase
        end
    end

    assign white = tcgr_pkg::white_value(r_cfg);

    tcgr_front u_front (
        .i_valid       (i_in_valid),
        .o_ready       (o_in_ready),
        .i_cell_row    (i_cell_row),
        .i_cell_column (i_cell_column),
        .i_char_code   (i_char_code),
        .i_line_pitch  (r_cfg.line_pitch),
        .i_pixel_bytes (r_cfg.pixel_bytes),
        .i_queue_full  (queue_full),
        .o_push        (push),
        .o_job         (push_job)
    );

    tcgr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (queue_full),
        .i_pop   (pop),
        .o_valid (head_valid),
        .o_job   (head_job)
    );

    tcgr_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_job_valid       (head_valid),
        .i_job             (head_job),
        .o_pop             (pop),
        .i_line_pitch      (r_cfg.line_pitch),
        .i_fore_color      (white),
        .o_valid           (o_out_valid),
        .i_ready           (i_out_ready),
        .o_scanline_offset (o_scanline_offset),
        .o_pixel_mask      (o_pixel_mask),
        .o_fore_color      (o_fore_color),
        .o_last_scanline   (o_last_scanline)
    );

endmodule

>>> hdl/tcgr_front.sv
`timescale 1ns / 1ps

module tcgr_front (
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [4:0]                           i_cell_row,
    input  logic [6:0]                           i_cell_column,
    input  logic [7:0]                           i_char_code,
    input  logic [15:0]                          i_line_pitch,
    input  logic [2:0]                           i_pixel_bytes,
    input  logic                                 i_queue_full,
    output logic                                 o_push,
    output tcgr_pkg::t_job                       o_job
);

    logic                          in_grid;
    logic [20:0]                   row_pitch;
    logic [11:0]                   x_bytes;

    assign in_grid = (32'(i_cell_row) < tcgr_pkg::GRID_ROWS) &&
                     (32'(i_cell_column) < tcgr_pkg::GRID_COLS);

    assign o_ready = !i_queue_full;
    assign o_push  = i_valid && o_ready && in_grid;

    // x offset: column * 8 pixels * bytes per pixel (3, any other value taken as 4)
    always_comb begin
        if (i_pixel_bytes == 3'd3) begin
            x_bytes = {1'b0, i_cell_column, 4'd0} + {2'd0, i_cell_column, 3'd0};
        end else begin
            x_bytes = {i_cell_column, 5'd0};
        end
    end

    assign row_pitch = 21'(i_cell_row) * 21'(i_line_pitch);

    always_comb begin
        o_job.base  = {row_pitch, 4'd0} + tcgr_pkg::OFFSET_W'(x_bytes);
        o_job.glyph = tcgr_pkg::classify(i_char_code);
    end

endmodule

>>> hdl/tcgr_queue.sv
`timescale 1ns / 1ps

module tcgr_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tcgr_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output tcgr_pkg::t_job o_job
);

    tcgr_pkg::t_job                          r_mem [tcgr_pkg::QUEUE_DEPTH];
    logic [tcgr_pkg::QUEUE_PTR_W-1:0]        r_wr_ptr;
    logic [tcgr_pkg::QUEUE_PTR_W-1:0]        r_rd_ptr;
    logic [tcgr_pkg::QUEUE_CNT_W-1:0]        r_count;
    logic [tcgr_pkg::QUEUE_PTR_W-1:0]        n_wr_ptr;
    logic [tcgr_pkg::QUEUE_PTR_W-1:0]        n_rd_ptr;
    logic                                    do_pop;

    assign o_full  = (32'(r_count) == tcgr_pkg::QUEUE_DEPTH);
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = (32'(r_wr_ptr) == tcgr_pkg::QUEUE_DEPTH - 1) ? '0 : r_wr_ptr + 1'b1;
        n_rd_ptr = (32'(r_rd_ptr) == tcgr_pkg::QUEUE_DEPTH - 1) ? '0 : r_rd_ptr + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

>>> hdl/tcgr_back.sv
`timescale 1ns / 1ps

module tcgr_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_job_valid,
    input  tcgr_pkg::t_job                  i_job,
    output logic                            o_pop,
    input  logic [15:0]                     i_line_pitch,
    input  logic [31:0]                     i_fore_color,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [tcgr_pkg::OFFSET_W-1:0]   o_scanline_offset,
    output logic [7:0]                      o_pixel_mask,
    output logic [31:0]                     o_fore_color,
    output logic                            o_last_scanline
);

    logic [tcgr_pkg::LINE_W-1:0]   r_line;
    logic [tcgr_pkg::OFFSET_W-1:0] r_acc;
    logic                          r_valid;
    logic [tcgr_pkg::OFFSET_W-1:0] r_offset;
    logic [7:0]                    r_mask;
    logic [31:0]                   r_color;
    logic                          r_last;

    logic                          advance;
    logic                          emit;
    logic                          is_last;
    logic [tcgr_pkg::OFFSET_W-1:0] cur_off;

    assign advance = !r_valid || i_ready;
    assign emit    = advance && i_job_valid;
    assign is_last = (32'(r_line) == tcgr_pkg::CELL_LINES - 1);
    assign o_pop   = emit && is_last;
    assign cur_off = (r_line == '0) ? i_job.base : r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line  <= '0;
            r_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_valid <= i_job_valid;
            end
            if (emit) begin
                r_line <= is_last ? '0 : r_line + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_acc    <= cur_off + tcgr_pkg::OFFSET_W'(i_line_pitch);
            r_offset <= cur_off;
            r_mask   <= tcgr_pkg::font_row(i_job.glyph, r_line[tcgr_pkg::LINE_W-1 -: 3]);
            r_color  <= i_fore_color;
            r_last   <= is_last;
        end
    end

    assign o_valid           = r_valid;
    assign o_scanline_offset = r_offset;
    assign o_pixel_mask      = r_mask;
    assign o_fore_color      = r_color;
    assign o_last_scanline   = r_last;

endmodule
